/* rtl/irq_bidirectional_remap_table_core_assert.svh */
// ----------------------------------------------------------------------------
// irq_bidirectional_remap_table_core_assert.svh
// Assertion macros for the interrupt remap table checker.
// ----------------------------------------------------------------------------
`ifndef IRQ_BIDIRECTIONAL_REMAP_TABLE_CORE_ASSERT_SVH
`define IRQ_BIDIRECTIONAL_REMAP_TABLE_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define IRQRMT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in %m");

// Same, with a message of the caller's choice.
`define IRQRMT_ASSERT_MSG(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

`endif

/* rtl/irqrmt_pkg.sv */
// ----------------------------------------------------------------------------
// irqrmt_pkg
// Types and constants shared by the interrupt remap table modules.
// ----------------------------------------------------------------------------
package irqrmt_pkg;

  localparam int NUM_W = 16;  // request number width
  localparam int TR_W  = 10;  // translated number / max_source width

  localparam logic [TR_W-1:0] MAX_SOURCE_RST = 10'd1023;

  // Request codes
  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_UNMAP = 2'd1;
  localparam logic [1:0] REQ_V2H   = 2'd2;
  localparam logic [1:0] REQ_H2V   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NUM_W-1:0] virt_num;
    logic [NUM_W-1:0] hw_num;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [TR_W-1:0] translated;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;    // write zero at the clear pointer
    logic capture;  // load an accepted request
    logic read;     // read both tables
    logic exec;     // check, write back, load result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

/* rtl/irqrmt_ctrl.sv */
// ----------------------------------------------------------------------------
// irqrmt_ctrl
// Sequencer: clearing pass after reset, then read / execute per request.
// ----------------------------------------------------------------------------
module irqrmt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  irqrmt_pkg::dp_stat_t stat,
  output irqrmt_pkg::ctl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_READ;
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        state_next = start ? S_READ : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Writes land at the end of EXEC, reads at the end of READ, so a new
  // request may be taken during EXEC.
  assign busy        = (state == S_CLEAR) || (state == S_READ);
  assign cmd.clear   = (state == S_CLEAR);
  assign cmd.capture = start && !busy;
  assign cmd.read    = (state == S_READ);
  assign cmd.exec    = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

endmodule

/* rtl/irqrmt_dp.sv */
// ----------------------------------------------------------------------------
// irqrmt_dp
// Forward and reverse tables, max_source register, request checks.
// ----------------------------------------------------------------------------
module irqrmt_dp #(
  parameter int NUM_IRQS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  irqrmt_pkg::ctl_cmd_t          cmd,
  input  irqrmt_pkg::req_t              req,
  input  logic                          cfg_we,
  input  logic [irqrmt_pkg::TR_W-1:0]   cfg_wdata,
  output irqrmt_pkg::dp_stat_t          stat,
  output irqrmt_pkg::rsp_t              result
);

  localparam int IW = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;

  logic [IW-1:0] fwd_mem [NUM_IRQS];
  logic [IW-1:0] rev_mem [NUM_IRQS];

  irqrmt_pkg::req_t              req_q;
  logic [irqrmt_pkg::TR_W-1:0]   max_source;
  logic [IW-1:0]                 clr_addr;
  logic [IW-1:0]                 fwd_rdata, rev_rdata;

  logic [IW-1:0] v_idx, h_idx;
  logic          v_ok, h_ok;
  logic [IW-1:0] fwd_tr, rev_tr, tr_iw;
  logic [31:0]   tr32;
  logic          fwd_we, rev_we;
  logic [IW-1:0] fwd_waddr, fwd_wdata, rev_waddr, rev_wdata;
  irqrmt_pkg::rsp_t result_next;

  assign v_idx = req_q.virt_num[IW-1:0];
  assign h_idx = req_q.hw_num[IW-1:0];
  assign v_ok  = (req_q.virt_num != '0) && (32'(req_q.virt_num) < NUM_IRQS);
  assign h_ok  = (req_q.hw_num != '0) && (32'(req_q.hw_num) < NUM_IRQS);

  // Zero entry means identity
  assign fwd_tr = (fwd_rdata != '0) ? fwd_rdata : v_idx;
  assign rev_tr = (rev_rdata != '0) ? rev_rdata : h_idx;

  assign stat.clr_last = (clr_addr == IW'(NUM_IRQS - 1));

  always_comb begin
    fwd_we      = 1'b0;
    fwd_waddr   = v_idx;
    fwd_wdata   = '0;
    rev_we      = 1'b0;
    rev_waddr   = h_idx;
    rev_wdata   = '0;
    tr_iw       = '0;
    result_next.status = irqrmt_pkg::ST_OK;
    if (cmd.clear) begin
      fwd_we    = 1'b1;
      fwd_waddr = clr_addr;
      rev_we    = 1'b1;
      rev_waddr = clr_addr;
    end else if (cmd.exec) begin
      unique case (req_q.req_type)
        irqrmt_pkg::REQ_MAP: begin
          if (!(v_ok && h_ok)) begin
            result_next.status = irqrmt_pkg::ST_INVAL;
          end else if (32'(fwd_tr) > 32'(max_source)) begin
            result_next.status = irqrmt_pkg::ST_INVAL;
          end else if (fwd_rdata != '0 || rev_rdata != '0) begin
            result_next.status = irqrmt_pkg::ST_ALREADY;
          end else begin
            fwd_we    = 1'b1;
            fwd_wdata = h_idx;
            rev_we    = 1'b1;
            rev_wdata = v_idx;
          end
        end
        irqrmt_pkg::REQ_UNMAP: begin
          if (!v_ok) begin
            result_next.status = irqrmt_pkg::ST_INVAL;
          end else if (fwd_rdata != '0) begin
            fwd_we    = 1'b1;
            rev_we    = 1'b1;
            rev_waddr = fwd_rdata;
          end
        end
        irqrmt_pkg::REQ_V2H: tr_iw = v_ok ? fwd_tr : '0;
        irqrmt_pkg::REQ_H2V: tr_iw = h_ok ? rev_tr : '0;
        default: tr_iw = '0;
      endcase
    end
    tr32 = 32'(tr_iw);
    result_next.translated = tr32[irqrmt_pkg::TR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_source <= irqrmt_pkg::MAX_SOURCE_RST;
      clr_addr   <= '0;
    end else begin
      if (cfg_we) max_source <= cfg_wdata;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
    if (cmd.exec) result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_waddr] <= fwd_wdata;
    if (cmd.read) fwd_rdata <= fwd_mem[v_idx];
  end

  always_ff @(posedge clk) begin
    if (rev_we) rev_mem[rev_waddr] <= rev_wdata;
    if (cmd.read) rev_rdata <= rev_mem[h_idx];
  end

endmodule

/* rtl/irq_bidirectional_remap_table_core.sv */
// ----------------------------------------------------------------------------
// irq_bidirectional_remap_table_core
// Forward / reverse interrupt number remap table with map, unmap and lookups.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------
//  request   | start / busy     | req (req_type, virt_num, hw_num)
//  result    | done (1 cycle)   | result (status, translated)
//  config    | cfg_we           | cfg_wdata (max_source)
//
//  A request reads both tables at their single read ports in READ, then
//  checks and writes back in EXEC; done pulses the cycle after that.
//  A new request is taken while the previous one is in its write-back cycle.
//  After reset a clearing pass over all NUM_IRQS entries zeroes both
//  tables with busy high; configuration writes are taken throughout.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module irq_bidirectional_remap_table_core #(
  parameter int NUM_IRQS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  irqrmt_pkg::req_t            req,
  output logic                        done,
  output irqrmt_pkg::rsp_t            result,
  input  logic                        cfg_we,
  input  logic [irqrmt_pkg::TR_W-1:0] cfg_wdata
);

  irqrmt_pkg::ctl_cmd_t cmd;
  irqrmt_pkg::dp_stat_t stat;

  irqrmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  irqrmt_dp #(
    .NUM_IRQS (NUM_IRQS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .result    (result)
  );

endmodule

/* rtl/irqrmt_chk.sv */
// ----------------------------------------------------------------------------
// irqrmt_chk
// Port-level checker for the interrupt remap table, bound to the top level.
// ----------------------------------------------------------------------------
`include "irq_bidirectional_remap_table_core_assert.svh"

module irqrmt_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input irqrmt_pkg::rsp_t result
);

  logic accept;
  logic st_known;

  assign accept   = start && !busy;
  assign st_known = (result.status == irqrmt_pkg::ST_OK) ||
                    (result.status == irqrmt_pkg::ST_INVAL) ||
                    (result.status == irqrmt_pkg::ST_ALREADY);

  // accepted request goes to the table read
  `IRQRMT_ASSERT(a_accept_busy, clk, rst, accept |=> busy)
  // every accepted request gets its result
  `IRQRMT_ASSERT_MSG(a_accept_done, clk, rst, accept |-> ##3 done, "result missing")
  `IRQRMT_ASSERT(a_done_gap, clk, rst, done |=> !done)
  `IRQRMT_ASSERT(a_status_code, clk, rst, done |-> st_known)
  // failed request never carries a translation
  `IRQRMT_ASSERT(a_fail_zero, clk, rst, (done && result.status != irqrmt_pkg::ST_OK) |-> (result.translated == '0))

endmodule

bind irq_bidirectional_remap_table_core irqrmt_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* bench/tb_irq_bidirectional_remap_table_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_irq_bidirectional_remap_table_core
// Drives map, unmap and lookup requests into the remap table with random
// gaps and checks each result against a scoreboard that keeps its own copy
// of both tables and of max_source.
// ----------------------------------------------------------------------------
module tb_irq_bidirectional_remap_table_core;
  import irqrmt_pkg::*;

  localparam int NUM_IRQS   = 1024;
  localparam int PHASE_REQS = 185;
  localparam int DRAIN_MAX  = 2000;

  class remap_scoreboard;
    logic [TR_W-1:0] fwd_map [NUM_IRQS];
    logic [TR_W-1:0] rev_map [NUM_IRQS];
    logic [TR_W-1:0] max_source;
    rsp_t            pending[$];
    int              errors;

    function new();
      foreach (fwd_map[i]) begin
        fwd_map[i] = '0;
        rev_map[i] = '0;
      end
      max_source = MAX_SOURCE_RST;
      errors     = 0;
    endfunction

    function bit num_ok(logic [NUM_W-1:0] n);
      return n != 0 && n < NUM_IRQS;
    endfunction

    // zero entry means identity
    function logic [TR_W-1:0] fwd_xlate(logic [NUM_W-1:0] v);
      if (!num_ok(v)) return '0;
      return (fwd_map[v[TR_W-1:0]] != 0) ? fwd_map[v[TR_W-1:0]] : v[TR_W-1:0];
    endfunction

    function logic [TR_W-1:0] rev_xlate(logic [NUM_W-1:0] h);
      if (!num_ok(h)) return '0;
      return (rev_map[h[TR_W-1:0]] != 0) ? rev_map[h[TR_W-1:0]] : h[TR_W-1:0];
    endfunction

    function void note_request(req_t r);
      rsp_t            exp;
      logic [TR_W-1:0] vi;
      logic [TR_W-1:0] hi;
      logic [TR_W-1:0] prev;
      exp.status     = ST_OK;
      exp.translated = '0;
      vi = r.virt_num[TR_W-1:0];
      hi = r.hw_num[TR_W-1:0];
      case (r.req_type)
        REQ_MAP: begin
          if (!num_ok(r.virt_num) || !num_ok(r.hw_num)) begin
            exp.status = ST_INVAL;
          end else if (fwd_xlate(r.virt_num) > max_source) begin
            exp.status = ST_INVAL;
          end else if (fwd_map[vi] != 0 || rev_map[hi] != 0) begin
            exp.status = ST_ALREADY;
          end else begin
            fwd_map[vi] = hi;
            rev_map[hi] = vi;
          end
        end
        REQ_UNMAP: begin
          if (!num_ok(r.virt_num)) begin
            exp.status = ST_INVAL;
          end else begin
            prev = fwd_map[vi];
            if (prev != 0) begin
              fwd_map[vi]   = '0;
              rev_map[prev] = '0;
            end
          end
        end
        REQ_V2H: exp.translated = fwd_xlate(r.virt_num);
        default: exp.translated = rev_xlate(r.hw_num);
      endcase
      pending.push_back(exp);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result status %0d translated %0d",
                   $time, got.status, got.translated);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.translated !== exp.translated) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch status exp %0d got %0d, translated exp %0d got %0d",
                   $time, exp.status, got.status, exp.translated, got.translated);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic                busy;
  req_t                req       = '0;
  logic                done;
  rsp_t                result;
  logic                cfg_we    = 1'b0;
  logic [TR_W-1:0]     cfg_wdata = '0;
  remap_scoreboard     sb;

  irq_bidirectional_remap_table_core #(
    .NUM_IRQS(NUM_IRQS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_result(result);
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // small pool near both ends of the table so maps collide often
  function automatic logic [NUM_W-1:0] pick_num();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return NUM_W'($urandom_range(1, 40));
    if (r < 70) return NUM_W'($urandom_range(990, 1023));
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return NUM_W'(1);
        2:       return NUM_W'(1023);
        3:       return NUM_W'(1024);
        default: return '1;
      endcase
    end
    if (r < 90) return NUM_W'($urandom);
    return NUM_W'($urandom_range(1, 1023));
  endfunction

  function automatic logic [1:0] pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return REQ_MAP;
    if (r < 55) return REQ_UNMAP;
    if (r < 77) return REQ_V2H;
    return REQ_H2V;
  endfunction

  task automatic send(logic [1:0] kind, logic [NUM_W-1:0] v, logic [NUM_W-1:0] h);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req.req_type <= kind;
    req.virt_num <= v;
    req.hw_num   <= h;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_source(logic [TR_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_source = val;
  endtask

  task automatic run_directed();
    // lookups on the empty tables, including out-of-range numbers
    send(REQ_V2H, 16'd0, 16'd0);
    send(REQ_V2H, 16'd1023, 16'hFFFF);
    send(REQ_V2H, 16'd1024, 16'd0);
    send(REQ_H2V, 16'hFFFF, 16'd1023);
    send(REQ_H2V, 16'd0, 16'hFFFF);
    // invalid map arguments
    send(REQ_MAP, 16'd0, 16'd5);
    send(REQ_MAP, 16'd5, 16'd0);
    send(REQ_MAP, 16'd1024, 16'd5);
    send(REQ_MAP, 16'd5, 16'hFFFF);
    // good map, then conflicts on both sides
    send(REQ_MAP, 16'd5, 16'd7);
    send(REQ_MAP, 16'd5, 16'd8);
    send(REQ_MAP, 16'd9, 16'd7);
    send(REQ_V2H, 16'd5, 16'd0);
    send(REQ_H2V, 16'd0, 16'd7);
    send(REQ_UNMAP, 16'd5, 16'hFFFF);
    send(REQ_UNMAP, 16'd5, 16'd0);
    send(REQ_UNMAP, 16'd0, 16'd0);
    send(REQ_UNMAP, 16'hFFFF, 16'd0);
    send(REQ_MAP, 16'd1023, 16'd1);
    send(REQ_MAP, 16'd1, 16'd1023);
    // forward translation above max_source
    write_max_source(10'd4);
    send(REQ_MAP, 16'd5, 16'd9);
    send(REQ_MAP, 16'd3, 16'd9);
    send(REQ_MAP, 16'd1023, 16'd2);
    send(REQ_UNMAP, 16'd3, 16'd0);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send(pick_req(), pick_num(), pick_num());
  endtask

  initial begin
    int cycles;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // written during the clearing pass
    write_max_source(MAX_SOURCE_RST);
    run_directed();
    write_max_source(10'd0);
    run_random(PHASE_REQS);
    write_max_source(10'd1023);
    run_random(PHASE_REQS);
    write_max_source(10'd512);
    run_random(PHASE_REQS);
    write_max_source(10'd1);
    run_random(PHASE_REQS);
    write_max_source(TR_W'($urandom_range(2, 1022)));
    run_random(PHASE_REQS);
    write_max_source(10'd1023);
    run_random(PHASE_REQS);
    start  <= 1'b0;
    cycles = 0;
    while (sb.pending.size() != 0 && cycles < DRAIN_MAX) begin
      @(posedge clk);
      cycles++;
    end
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
